@@ design/linked_deque_with_erase_defines.svh @@
// ----------------------------------------------------------------------------
// linked_deque_with_erase_defines
// assertion macros shared by the linked deque design
// ----------------------------------------------------------------------------
`ifndef LINKED_DEQUE_WITH_ERASE_DEFINES_SVH
`define LINKED_DEQUE_WITH_ERASE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define LDQ_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define LDQ_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/ldq_pkg.sv @@
// ----------------------------------------------------------------------------
// ldq_pkg
// sizes, codes and helper types of the linked deque
// ----------------------------------------------------------------------------
package ldq_pkg;

    localparam int CAPACITY    = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int SLOT_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int COUNT_W     = $clog2(CAPACITY + 1);

    localparam int OP_W        = 3;
    localparam int DATA_W      = 32;
    localparam int STATUS_W    = 2;
    localparam int CNT_OUT_W   = 5;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 40;
    localparam int M_PAD_W     = M_TDATA_W - DATA_W - STATUS_W - CNT_OUT_W;

    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd1;
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
    localparam logic [OP_W-1:0] OP_ERASE      = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [SLOT_W-1:0] nxt;
        logic [SLOT_W-1:0] prv;
    } link_t;

    // lowest free slot index
    function automatic logic [SLOT_W-1:0] first_free(input logic [CAPACITY-1:0] used);
        logic [SLOT_W-1:0] slot;
        slot = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (!used[i]) begin
                slot = SLOT_W'(i);
            end
        end
        return slot;
    endfunction

endpackage

@@ design/ldq_ram.sv @@
// ----------------------------------------------------------------------------
// ldq_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module ldq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             aclk,
    input  logic                             we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ design/linked_deque_with_erase.sv @@
// ----------------------------------------------------------------------------
// linked_deque_with_erase
// bounded deque of linked entries with push, pop and erase of first match
// ----------------------------------------------------------------------------
// One transaction is taken at a time. Values sit in one ram and the next and
// previous links in a second ram, both with a registered read port; head,
// tail, count and the slot-in-use bits are flip-flops. An erase walks the
// links at one entry per cycle on the link ram read port. The result waits in
// an output register while the next transaction is taken.
// ----------------------------------------------------------------------------
`include "linked_deque_with_erase_defines.svh"

module linked_deque_with_erase (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [ldq_pkg::S_TDATA_W-1:0]  s_tdata,   // opcode, operand_value
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ldq_pkg::M_TDATA_W-1:0]  m_tdata    // removed_value, status, entry_count
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH_FIX,
        S_POP_RD,
        S_WALK,
        S_UNL_P,
        S_UNL_N,
        S_RESP
    } state_t;

    state_t state_reg, state_next;

    logic [ldq_pkg::SLOT_W-1:0]      head_reg, head_next;
    logic [ldq_pkg::SLOT_W-1:0]      tail_reg, tail_next;
    logic [ldq_pkg::COUNT_W-1:0]     count_reg, count_next;
    logic [ldq_pkg::CAPACITY-1:0]    in_use_reg, in_use_next;
    logic [ldq_pkg::SLOT_W-1:0]      slot_reg, slot_next;
    logic [ldq_pkg::SLOT_W-1:0]      fix_reg, fix_next;
    logic [ldq_pkg::SLOT_W-1:0]      p_reg, p_next;
    logic [ldq_pkg::SLOT_W-1:0]      n_reg, n_next;
    logic                            is_tail_reg, is_tail_next;
    logic                            back_reg, back_next;
    logic [ldq_pkg::VALUE_WIDTH-1:0] key_reg, key_next;
    logic [ldq_pkg::COUNT_W-1:0]     step_reg, step_next;
    logic [ldq_pkg::VALUE_WIDTH-1:0] rem_reg, rem_next;
    logic [ldq_pkg::STATUS_W-1:0]    status_reg, status_next;
    logic                            m_tvalid_reg, m_tvalid_next;
    logic [ldq_pkg::M_TDATA_W-1:0]   m_tdata_reg, m_tdata_next;

    logic                            val_we;
    logic [ldq_pkg::SLOT_W-1:0]      val_waddr;
    logic [ldq_pkg::VALUE_WIDTH-1:0] val_wdata;
    logic [ldq_pkg::VALUE_WIDTH-1:0] val_rdata;
    logic                            lnk_we;
    logic [ldq_pkg::SLOT_W-1:0]      lnk_waddr;
    ldq_pkg::link_t                  lnk_wdata;
    ldq_pkg::link_t                  lnk_rdata;
    logic [ldq_pkg::SLOT_W-1:0]      rd_addr;

    logic [ldq_pkg::OP_W-1:0]        op_in;
    logic [ldq_pkg::VALUE_WIDTH-1:0] operand_in;
    logic [ldq_pkg::SLOT_W-1:0]      free_slot;
    logic                            accept;
    logic                            unl_go;
    logic                            unl_head;
    logic                            unl_tail;

    assign op_in      = s_tdata[ldq_pkg::OP_W-1:0];
    assign operand_in = ldq_pkg::VALUE_WIDTH'(s_tdata[ldq_pkg::OP_W +: ldq_pkg::DATA_W]);
    assign free_slot  = ldq_pkg::first_free(in_use_reg);
    assign s_tready   = (state_reg == S_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign unl_head   = (slot_reg == head_reg);
    assign unl_tail   = (slot_reg == tail_reg);

    ldq_ram #(
        .WIDTH (ldq_pkg::VALUE_WIDTH),
        .DEPTH (ldq_pkg::CAPACITY)
    ) u_val_ram (
        .aclk  (aclk),
        .we    (val_we),
        .waddr (val_waddr),
        .wdata (val_wdata),
        .raddr (rd_addr),
        .rdata (val_rdata)
    );

    ldq_ram #(
        .WIDTH ($bits(ldq_pkg::link_t)),
        .DEPTH (ldq_pkg::CAPACITY)
    ) u_lnk_ram (
        .aclk  (aclk),
        .we    (lnk_we),
        .waddr (lnk_waddr),
        .wdata (lnk_wdata),
        .raddr (rd_addr),
        .rdata (lnk_rdata)
    );

    always_comb begin
        state_next    = state_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        in_use_next   = in_use_reg;
        slot_next     = slot_reg;
        fix_next      = fix_reg;
        p_next        = p_reg;
        n_next        = n_reg;
        is_tail_next  = is_tail_reg;
        back_next     = back_reg;
        key_next      = key_reg;
        step_next     = step_reg;
        rem_next      = rem_reg;
        status_next   = status_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        val_we        = 1'b0;
        val_waddr     = free_slot;
        val_wdata     = key_reg;
        lnk_we        = 1'b0;
        lnk_waddr     = free_slot;
        lnk_wdata     = '0;
        rd_addr       = head_reg;
        unl_go        = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (op_in == ldq_pkg::OP_POP_BACK || op_in == ldq_pkg::OP_PUSH_BACK) begin
                    rd_addr = tail_reg;
                end
                if (accept) begin
                    key_next    = operand_in;
                    rem_next    = '0;
                    status_next = ldq_pkg::ST_OK;
                    back_next   = (op_in == ldq_pkg::OP_PUSH_BACK);
                    state_next  = S_RESP;
                    unique case (op_in)
                        ldq_pkg::OP_PUSH_BACK, ldq_pkg::OP_PUSH_FRONT: begin
                            if (count_reg < ldq_pkg::COUNT_W'(ldq_pkg::CAPACITY)) begin
                                val_we                 = 1'b1;
                                val_wdata              = operand_in;
                                lnk_we                 = 1'b1;
                                in_use_next[free_slot] = 1'b1;
                                count_next             = count_reg + 1'b1;
                                slot_next              = free_slot;
                                if (count_reg == '0) begin
                                    head_next = free_slot;
                                    tail_next = free_slot;
                                end else if (op_in == ldq_pkg::OP_PUSH_BACK) begin
                                    lnk_wdata.prv = tail_reg;
                                    fix_next      = tail_reg;
                                    tail_next     = free_slot;
                                    state_next    = S_PUSH_FIX;
                                end else begin
                                    lnk_wdata.nxt = head_reg;
                                    fix_next      = head_reg;
                                    head_next     = free_slot;
                                    state_next    = S_PUSH_FIX;
                                end
                            end else begin
                                status_next = ldq_pkg::ST_FULL;
                            end
                        end
                        ldq_pkg::OP_POP_BACK, ldq_pkg::OP_POP_FRONT: begin
                            if (count_reg == '0) begin
                                status_next = ldq_pkg::ST_EMPTY;
                            end else begin
                                slot_next  = rd_addr;
                                state_next = S_POP_RD;
                            end
                        end
                        ldq_pkg::OP_ERASE: begin
                            if (count_reg == '0) begin
                                status_next = ldq_pkg::ST_NOT_FOUND;
                            end else begin
                                slot_next  = head_reg;
                                step_next  = '0;
                                state_next = S_WALK;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_PUSH_FIX: begin
                lnk_we    = 1'b1;
                lnk_waddr = fix_reg;
                if (back_reg) begin
                    lnk_wdata.nxt = slot_reg;
                    lnk_wdata.prv = lnk_rdata.prv;
                end else begin
                    lnk_wdata.nxt = lnk_rdata.nxt;
                    lnk_wdata.prv = slot_reg;
                end
                state_next = S_RESP;
            end
            S_POP_RD: begin
                rem_next = val_rdata;
                unl_go   = 1'b1;
            end
            S_WALK: begin
                if (val_rdata == key_reg) begin
                    unl_go = 1'b1;
                end else if (step_reg == ldq_pkg::COUNT_W'(count_reg - 1'b1)) begin
                    status_next = ldq_pkg::ST_NOT_FOUND;
                    state_next  = S_RESP;
                end else begin
                    rd_addr   = lnk_rdata.nxt;
                    slot_next = lnk_rdata.nxt;
                    step_next = step_reg + 1'b1;
                end
            end
            S_UNL_P: begin
                lnk_we        = 1'b1;
                lnk_waddr     = p_reg;
                lnk_wdata.nxt = n_reg;
                lnk_wdata.prv = lnk_rdata.prv;
                if (!is_tail_reg) begin
                    rd_addr    = n_reg;
                    state_next = S_UNL_N;
                end else begin
                    state_next = S_RESP;
                end
            end
            S_UNL_N: begin
                lnk_we        = 1'b1;
                lnk_waddr     = n_reg;
                lnk_wdata.nxt = lnk_rdata.nxt;
                lnk_wdata.prv = p_reg;
                state_next    = S_RESP;
            end
            S_RESP: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{ldq_pkg::M_PAD_W{1'b0}},
                                     ldq_pkg::CNT_OUT_W'(count_reg),
                                     status_reg,
                                     ldq_pkg::DATA_W'(rem_reg)};
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // unlink slot_reg, its links are on the link ram read port
        if (unl_go) begin
            p_next                = lnk_rdata.prv;
            n_next                = lnk_rdata.nxt;
            is_tail_next          = unl_tail;
            status_next           = ldq_pkg::ST_OK;
            in_use_next[slot_reg] = 1'b0;
            count_next            = count_reg - 1'b1;
            if (unl_head) begin
                head_next = lnk_rdata.nxt;
            end
            if (unl_tail) begin
                tail_next = lnk_rdata.prv;
            end
            if (count_reg == ldq_pkg::COUNT_W'(1)) begin
                head_next = '0;
                tail_next = '0;
            end
            if (!unl_head) begin
                rd_addr    = lnk_rdata.prv;
                state_next = S_UNL_P;
            end else if (!unl_tail) begin
                rd_addr    = lnk_rdata.nxt;
                state_next = S_UNL_N;
            end else begin
                state_next = S_RESP;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
            in_use_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            count_reg    <= count_next;
            in_use_reg   <= in_use_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        slot_reg    <= slot_next;
        fix_reg     <= fix_next;
        p_reg       <= p_next;
        n_reg       <= n_next;
        is_tail_reg <= is_tail_next;
        back_reg    <= back_next;
        key_reg     <= key_next;
        step_reg    <= step_next;
        rem_reg     <= rem_next;
        status_reg  <= status_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `LDQ_ASSERT_IMP(a_count_matches_use, aclk, aresetn, 1'b1, $countones(in_use_reg) == count_reg, "entry count differs from slots in use")
    `LDQ_ASSERT_IMP(a_empty_ends_zero, aclk, aresetn, count_reg == '0, head_reg == '0 && tail_reg == '0, "empty list with nonzero head or tail")
    `LDQ_ASSERT_IMP(a_ends_in_use, aclk, aresetn, count_reg != '0, in_use_reg[head_reg] && in_use_reg[tail_reg], "head or tail slot not in use")
    `LDQ_ASSERT_NXT(a_accept_leaves_idle, aclk, aresetn, s_tvalid && s_tready, state_reg != S_IDLE, "accepted transaction did not start")

endmodule

@@ verif/tb_linked_deque_with_erase.sv @@
// ----------------------------------------------------------------------------
// tb_linked_deque_with_erase
// self-checking bench for the linked deque: push, pop and erase of first match
// ----------------------------------------------------------------------------
// A directed table covers the empty list, the full store, unused opcodes and
// erase at head, middle and tail. Random requests then fill and drain the
// list repeatedly under four idle/stall settings. Every result is checked
// against the table's expected result or a queue-based model of the list contents.
// ----------------------------------------------------------------------------
module tb_linked_deque_with_erase;
    timeunit 1ns;
    timeprecision 1ps;

    import ldq_pkg::*;

    localparam logic [OP_W-1:0] OP_SPARE_5 = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;
    localparam int RANDOM_PER_PHASE = 175;
    localparam int DRAIN_CYCLES     = 40;

    typedef struct packed {
        logic [DATA_W-1:0]    removed;
        logic [STATUS_W-1:0]  status;
        logic [CNT_OUT_W-1:0] count;
    } deque_result_t;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [DATA_W-1:0] value;
        logic [4:0]        rep;
        logic              typed;
        deque_result_t     want;
    } directed_row_t;

    localparam int N_DIRECTED = 20;

    directed_row_t directed_rows [N_DIRECTED] = '{
        '{OP_POP_BACK,   32'h0,        5'd1, 1'b1, '{32'h0, ST_EMPTY, 5'd0}},
        '{OP_POP_FRONT,  32'h0,        5'd1, 1'b1, '{32'h0, ST_EMPTY, 5'd0}},
        '{OP_ERASE,      32'h0,        5'd1, 1'b1, '{32'h0, ST_NOT_FOUND, 5'd0}},
        '{OP_SPARE_5,    32'hFFFFFFFF, 5'd1, 1'b1, '{32'h0, ST_OK, 5'd0}},
        '{OP_SPARE_7,    32'h0,        5'd1, 1'b1, '{32'h0, ST_OK, 5'd0}},
        '{OP_PUSH_BACK,  32'hFFFFFFFF, 5'd1, 1'b1, '{32'h0, ST_OK, 5'd1}},
        '{OP_POP_BACK,   32'h0,        5'd1, 1'b1, '{32'hFFFFFFFF, ST_OK, 5'd0}},
        '{OP_PUSH_FRONT, 32'h0,        5'd1, 1'b1, '{32'h0, ST_OK, 5'd1}},
        '{OP_POP_FRONT,  32'h0,        5'd1, 1'b1, '{32'h0, ST_OK, 5'd0}},
        '{OP_PUSH_BACK,  32'hA5A55A5A, 5'd8, 1'b0, '0},
        '{OP_PUSH_FRONT, 32'h12340000, 5'd8, 1'b0, '0},
        '{OP_PUSH_BACK,  32'h1,        5'd1, 1'b1, '{32'h0, ST_FULL, 5'd16}},
        '{OP_PUSH_FRONT, 32'h2,        5'd1, 1'b1, '{32'h0, ST_FULL, 5'd16}},
        '{OP_ERASE,      32'hA5A55A5D, 5'd1, 1'b0, '0},
        '{OP_ERASE,      32'hDEADBEEF, 5'd1, 1'b0, '0},
        '{OP_ERASE,      32'h12340007, 5'd1, 1'b0, '0},
        '{OP_ERASE,      32'hA5A55A61, 5'd1, 1'b0, '0},
        '{OP_SPARE_6,    32'h55555555, 5'd1, 1'b0, '0},
        '{OP_POP_FRONT,  32'h0,        5'd4, 1'b0, '0},
        '{OP_POP_BACK,   32'h0,        5'd4, 1'b0, '0}
    };

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    logic [DATA_W-1:0] held_values [$];
    deque_result_t     pending_results [$];

    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int fail_count = 0;
    int accepted_count = 0;
    int checked_count = 0;
    int full_count = 0;
    int empty_count = 0;
    int not_found_count = 0;
    int erase_hit_count = 0;

    linked_deque_with_erase dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic deque_result_t predict_request(input logic [OP_W-1:0] op,
                                                      input logic [DATA_W-1:0] val);
        deque_result_t r;
        int hit;
        r = '0;
        hit = -1;
        case (op)
            OP_PUSH_BACK, OP_PUSH_FRONT: begin
                if (held_values.size() >= CAPACITY) begin
                    r.status = ST_FULL;
                end else if (op == OP_PUSH_BACK) begin
                    held_values.push_back(val);
                end else begin
                    held_values.push_front(val);
                end
            end
            OP_POP_BACK: begin
                if (held_values.size() == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.removed = held_values.pop_back();
                end
            end
            OP_POP_FRONT: begin
                if (held_values.size() == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.removed = held_values.pop_front();
                end
            end
            OP_ERASE: begin
                foreach (held_values[i]) begin
                    if (hit < 0 && held_values[i] == val) begin
                        hit = i;
                    end
                end
                if (hit < 0) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    held_values.delete(hit);
                end
            end
            default: ;
        endcase
        r.count = CNT_OUT_W'(held_values.size());
        return r;
    endfunction

    // mostly a small set of values so that duplicates and erase hits are common
    function automatic logic [DATA_W-1:0] pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 55) begin
            return DATA_W'($urandom_range(7));
        end else if (r < 75) begin
            case ($urandom_range(3))
                0: return '0;
                1: return '1;
                2: return {1'b1, {(DATA_W-1){1'b0}}};
                default: return {1'b0, {(DATA_W-1){1'b1}}};
            endcase
        end
        return DATA_W'($urandom());
    endfunction

    task automatic send_request(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] val,
                                input logic typed, input deque_result_t want);
        deque_result_t predicted;
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({val, op});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted = predict_request(op, val);
        pending_results.push_back(typed ? want : predicted);
        accepted_count++;
        @(negedge aclk);
    endtask

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge aclk) begin
        deque_result_t got;
        deque_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.removed = m_tdata[DATA_W-1:0];
            got.status  = m_tdata[DATA_W +: STATUS_W];
            got.count   = m_tdata[DATA_W+STATUS_W +: CNT_OUT_W];
            if (pending_results.size() == 0) begin
                $display("%0t unexpected result: removed %h status %0d count %0d",
                         $time, got.removed, got.status, got.count);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                checked_count++;
                if (got !== want) begin
                    $display("%0t mismatch: expected removed %h status %0d count %0d, %s",
                             $time, want.removed, want.status, want.count, "got");
                    $display("%0t           actual   removed %h status %0d count %0d",
                             $time, got.removed, got.status, got.count);
                    fail_count++;
                end
            end
            case (got.status)
                ST_FULL:      full_count++;
                ST_EMPTY:     empty_count++;
                ST_NOT_FOUND: not_found_count++;
                default:      ;
            endcase
        end
    end

    initial begin
        int useful;
        int run_len;
        int r;
        logic filling;
        logic [OP_W-1:0] op;
        logic [DATA_W-1:0] val;

        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_rows[i]) begin
            for (int k = 0; k < directed_rows[i].rep; k++) begin
                send_request(directed_rows[i].op, directed_rows[i].value + DATA_W'(k),
                             directed_rows[i].typed, directed_rows[i].want);
            end
        end

        filling = 1'b1;
        run_len = $urandom_range(60, 20);
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 50; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 50; end
                default: begin src_idle_pct = 15; sink_stall_pct = 15; end
            endcase
            useful = 0;
            while (useful < RANDOM_PER_PHASE) begin
                if (--run_len == 0) begin
                    filling = ~filling;
                    run_len = $urandom_range(60, 20);
                end
                r = $urandom_range(99);
                val = pick_value();
                if (r < 3) begin
                    op = OP_W'($urandom_range(OP_SPARE_7, OP_SPARE_5));
                end else if (r < 18) begin
                    op = OP_ERASE;
                    if (held_values.size() != 0 && $urandom_range(9) < 7) begin
                        val = held_values[$urandom_range(held_values.size() - 1)];
                    end
                end else if (r < (filling ? 73 : 43)) begin
                    op = $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
                end else begin
                    op = $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
                end
                if (op == OP_ERASE && held_values.size() != 0) begin
                    foreach (held_values[i]) begin
                        if (held_values[i] == val) begin
                            erase_hit_count++;
                            break;
                        end
                    end
                end
                send_request(op, val, 1'b0, '0);
                if (op < OP_SPARE_5) begin
                    useful++;
                end
            end
        end
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("run covered %0d requests and %0d checked results", accepted_count,
                 checked_count);
        $display("refused pushes %0d, empty pops %0d, missed erases %0d, random erase hits %0d",
                 full_count, empty_count, not_found_count, erase_hit_count);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
